// ----- hdl/scpt_pkg.sv -----
package scpt_pkg;

  // default geometry of the coordinate words
  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 12;

  // degenerate axis: |e-s|^2 * DEG_SCALE < 2^(2*FRAC_BITS)
  localparam logic [63:0] DEG_SCALE = 64'd1000000;
  // the derived limit stays below 2^21 for any fraction width up to 20
  localparam int DEG_LIM_BITS = 21;

  typedef struct packed {
    logic deg;      // axis shorter than the minimum length
    logic caps_ok;  // point lies between both end cap planes
  } scpt_flags_t;

endpackage

// ----- hdl/scpt_front.sv -----
module scpt_front import scpt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int DFW = COORD_BITS + 1,
  localparam int PW  = 2 * DFW
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic signed [COORD_BITS-1:0] s_x,
  input  logic signed [COORD_BITS-1:0] s_y,
  input  logic signed [COORD_BITS-1:0] s_z,
  input  logic signed [COORD_BITS-1:0] e_x,
  input  logic signed [COORD_BITS-1:0] e_y,
  input  logic signed [COORD_BITS-1:0] e_z,
  input  logic signed [COORD_BITS-1:0] q_x,
  input  logic signed [COORD_BITS-1:0] q_y,
  input  logic signed [COORD_BITS-1:0] q_z,
  input  logic        [COORD_BITS-2:0] rad,
  output logic                         vld_o,
  output logic signed [PW-1:0]         dd_p [3],
  output logic signed [PW-1:0]         ad_p [3],
  output logic signed [PW-1:0]         bd_p [3],
  output logic signed [PW-1:0]         xp_p [3],
  output logic signed [PW-1:0]         xn_p [3],
  output logic [2*COORD_BITS-3:0]      r2_p
);

  logic signed [COORD_BITS-1:0] s_v [3];
  logic signed [COORD_BITS-1:0] e_v [3];
  logic signed [COORD_BITS-1:0] q_v [3];

  // stage 1: axis and offset vectors
  logic                  vld1_r;
  logic signed [DFW-1:0] d_r [3];
  logic signed [DFW-1:0] a_r [3];
  logic signed [DFW-1:0] b_r [3];
  logic [COORD_BITS-2:0] rad_r;

  // stage 2: products
  logic                     vld2_r;
  logic signed [PW-1:0]     dd_r [3];
  logic signed [PW-1:0]     ad_r [3];
  logic signed [PW-1:0]     bd_r [3];
  logic signed [PW-1:0]     xp_r [3];
  logic signed [PW-1:0]     xn_r [3];
  logic [2*COORD_BITS-3:0]  r2_r;

  always_comb begin
    s_v[0] = s_x; s_v[1] = s_y; s_v[2] = s_z;
    e_v[0] = e_x; e_v[1] = e_y; e_v[2] = e_z;
    q_v[0] = q_x; q_v[1] = q_y; q_v[2] = q_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[i]  <= DFW'(e_v[i]) - DFW'(s_v[i]);
        a_r[i]  <= DFW'(q_v[i]) - DFW'(s_v[i]);
        b_r[i]  <= DFW'(q_v[i]) - DFW'(e_v[i]);
        dd_r[i] <= d_r[i] * d_r[i];
        ad_r[i] <= a_r[i] * d_r[i];
        bd_r[i] <= b_r[i] * d_r[i];
        // cross product terms: c[i] = a[i+1]*b[i+2] - a[i+2]*b[i+1]
        xp_r[i] <= a_r[(i+1)%3] * b_r[(i+2)%3];
        xn_r[i] <= a_r[(i+2)%3] * b_r[(i+1)%3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= rad;
      r2_r  <= rad_r * rad_r;
    end
  end

  assign vld_o = vld2_r;
  assign dd_p  = dd_r;
  assign ad_p  = ad_r;
  assign bd_p  = bd_r;
  assign xp_p  = xp_r;
  assign xn_p  = xn_r;
  assign r2_p  = r2_r;

endmodule

// ----- hdl/scpt_reduce.sv -----
module scpt_reduce import scpt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int PW  = 2 * COORD_BITS + 2,
  localparam int CW  = 2 * COORD_BITS + 2,
  localparam int H   = CW / 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic signed [PW-1:0]    dd_p [3],
  input  logic signed [PW-1:0]    ad_p [3],
  input  logic signed [PW-1:0]    bd_p [3],
  input  logic signed [PW-1:0]    xp_p [3],
  input  logic signed [PW-1:0]    xn_p [3],
  input  logic [2*COORD_BITS-3:0] r2_p,
  output logic                    vld_o,
  output scpt_flags_t             flags_o,
  output logic [2*H-1:0]          sq_hh [3],
  output logic [2*H-1:0]          sq_hl [3],
  output logic [2*H-1:0]          sq_ll [3],
  output logic [2*H-1:0]          rr_hh,
  output logic [2*H-1:0]          rr_hl,
  output logic [2*H-1:0]          rr_lh,
  output logic [2*H-1:0]          rr_ll
);

  localparam int SW  = PW + 2;
  localparam int CSW = PW + 1;
  localparam int LB  = DEG_LIM_BITS;
  localparam logic [63:0] DEG_LIM =
    ((64'd1 << (2 * FRAC_BITS)) - 64'd1) / DEG_SCALE + 64'd1;

  logic signed [SW-1:0]  dd_sum, ad_sum, bd_sum;
  logic signed [CSW-1:0] c_v [3];
  logic [CW-1:0]         cabs [3];

  // stage 3: sums, cap tests, cross magnitudes
  logic          vld3_r;
  logic          caps3_r;
  logic [CW-1:0] dd3_r;
  logic [CW-1:0] cab3_r [3];
  logic [CW-1:0] r23_r;

  // stage 4: partial products of the squares
  logic        vld4_r;
  scpt_flags_t flags4_r;
  logic [2*H-1:0] hh4_r [3];
  logic [2*H-1:0] hl4_r [3];
  logic [2*H-1:0] ll4_r [3];
  logic [2*H-1:0] rhh4_r, rhl4_r, rlh4_r, rll4_r;

  always_comb begin
    dd_sum = SW'(dd_p[0]) + SW'(dd_p[1]) + SW'(dd_p[2]);
    ad_sum = SW'(ad_p[0]) + SW'(ad_p[1]) + SW'(ad_p[2]);
    bd_sum = SW'(bd_p[0]) + SW'(bd_p[1]) + SW'(bd_p[2]);
  end

  for (genvar i = 0; i < 3; i++) begin : g_cross
    assign c_v[i]  = CSW'(xp_p[i]) - CSW'(xn_p[i]);
    assign cabs[i] = c_v[i][CSW-1] ? CW'(-c_v[i]) : CW'(c_v[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        cab3_r[i] <= cabs[i];
        hh4_r[i]  <= cab3_r[i][CW-1:H] * cab3_r[i][CW-1:H];
        hl4_r[i]  <= cab3_r[i][CW-1:H] * cab3_r[i][H-1:0];
        ll4_r[i]  <= cab3_r[i][H-1:0]  * cab3_r[i][H-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld3_r <= vld_i;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // (q-s).d >= 0 and (q-e).(-d) >= 0
      caps3_r <= !ad_sum[SW-1] && (bd_sum[SW-1] || (bd_sum == '0));
      dd3_r   <= dd_sum[CW-1:0];
      r23_r   <= CW'(r2_p);

      flags4_r.caps_ok <= caps3_r;
      flags4_r.deg     <= (dd3_r[CW-1:LB] == '0) && (dd3_r[LB-1:0] < DEG_LIM[LB-1:0]);
      rhh4_r <= r23_r[CW-1:H] * dd3_r[CW-1:H];
      rhl4_r <= r23_r[CW-1:H] * dd3_r[H-1:0];
      rlh4_r <= r23_r[H-1:0]  * dd3_r[CW-1:H];
      rll4_r <= r23_r[H-1:0]  * dd3_r[H-1:0];
    end
  end

  assign vld_o   = vld4_r;
  assign flags_o = flags4_r;
  assign sq_hh   = hh4_r;
  assign sq_hl   = hl4_r;
  assign sq_ll   = ll4_r;
  assign rr_hh   = rhh4_r;
  assign rr_hl   = rhl4_r;
  assign rr_lh   = rlh4_r;
  assign rr_ll   = rll4_r;

endmodule

// ----- hdl/scpt_decide.sv -----
module scpt_decide import scpt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CW = 2 * COORD_BITS + 2,
  localparam int H  = CW / 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  scpt_flags_t    flags_i,
  input  logic [2*H-1:0] sq_hh [3],
  input  logic [2*H-1:0] sq_hl [3],
  input  logic [2*H-1:0] sq_ll [3],
  input  logic [2*H-1:0] rr_hh,
  input  logic [2*H-1:0] rr_hl,
  input  logic [2*H-1:0] rr_lh,
  input  logic [2*H-1:0] rr_ll,
  output logic           vld_o,
  output logic           inside_o,
  output logic           deg_o
);

  localparam int LW = 2 * CW + 2;

  // stage 5: recombined squares
  logic          vld5_r;
  scpt_flags_t   flags5_r;
  logic [LW-1:0] sq5_r [3];
  logic [LW-1:0] rhs5_r;

  // stage 6: output register
  logic          vld6_r;
  logic          inside6_r;
  logic          deg6_r;

  logic [LW-1:0] lhs;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        sq5_r[i] <= (LW'(sq_hh[i]) << (2 * H)) + (LW'(sq_hl[i]) << (H + 1))
                    + LW'(sq_ll[i]);
      end
    end
  end

  assign lhs = sq5_r[0] + sq5_r[1] + sq5_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else if (en) begin
      vld5_r <= vld_i;
      vld6_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags5_r  <= flags_i;
      rhs5_r    <= (LW'(rr_hh) << (2 * H)) + ((LW'(rr_hl) + LW'(rr_lh)) << H)
                   + LW'(rr_ll);
      inside6_r <= flags5_r.deg || (flags5_r.caps_ok && (lhs < rhs5_r));
      deg6_r    <= flags5_r.deg;
    end
  end

  assign vld_o    = vld6_r;
  assign inside_o = inside6_r;
  assign deg_o    = deg6_r;

endmodule

// ----- hdl/segment_cylinder_point_test_top.sv -----
// Channel  Direction  Handshake             Payload
// in_      request    in_valid / in_stall   axis start, axis end, query point, radius
// out_     result     out_valid / out_stall inside_res, degenerate
//
// One request per clock while out_stall holds no result; each result follows its request through every stage.
// Stage set: differences, products, sums and cross magnitudes, split squares,
// recombination, final compare. The 102-bit squared compare sets the depth.
// Reset (synchronous, rst_n low) clears only the valid bits of the six stages.
// A result held by out_stall freezes the whole pipe at once; in_stall follows it directly.
module segment_cylinder_point_test_top import scpt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_start_z,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic signed [COORD_BITS-1:0] in_end_z,
  input  logic signed [COORD_BITS-1:0] in_query_x,
  input  logic signed [COORD_BITS-1:0] in_query_y,
  input  logic signed [COORD_BITS-1:0] in_query_z,
  input  logic        [COORD_BITS-2:0] in_cyl_radius,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_inside_res,
  output logic                         out_degenerate
);

  localparam int PW = 2 * COORD_BITS + 2;
  localparam int H  = COORD_BITS + 1;

  // one enable for every stage: the pipe moves unless a held result is stalled
  logic en;

  logic                    vld2;
  logic signed [PW-1:0]    dd_p [3];
  logic signed [PW-1:0]    ad_p [3];
  logic signed [PW-1:0]    bd_p [3];
  logic signed [PW-1:0]    xp_p [3];
  logic signed [PW-1:0]    xn_p [3];
  logic [2*COORD_BITS-3:0] r2_p;

  logic           vld4;
  scpt_flags_t    flags4;
  logic [2*H-1:0] sq_hh [3];
  logic [2*H-1:0] sq_hl [3];
  logic [2*H-1:0] sq_ll [3];
  logic [2*H-1:0] rr_hh, rr_hl, rr_lh, rr_ll;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stages 1-2: axis / offset vectors, then all first-level products
  scpt_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .s_x    (in_start_x),
    .s_y    (in_start_y),
    .s_z    (in_start_z),
    .e_x    (in_end_x),
    .e_y    (in_end_y),
    .e_z    (in_end_z),
    .q_x    (in_query_x),
    .q_y    (in_query_y),
    .q_z    (in_query_z),
    .rad    (in_cyl_radius),
    .vld_o  (vld2),
    .dd_p   (dd_p),
    .ad_p   (ad_p),
    .bd_p   (bd_p),
    .xp_p   (xp_p),
    .xn_p   (xn_p),
    .r2_p   (r2_p)
  );

  // stages 3-4: dot sums and cap tests, then half-word products of the squares
  scpt_reduce #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (vld2),
    .dd_p    (dd_p),
    .ad_p    (ad_p),
    .bd_p    (bd_p),
    .xp_p    (xp_p),
    .xn_p    (xn_p),
    .r2_p    (r2_p),
    .vld_o   (vld4),
    .flags_o (flags4),
    .sq_hh   (sq_hh),
    .sq_hl   (sq_hl),
    .sq_ll   (sq_ll),
    .rr_hh   (rr_hh),
    .rr_hl   (rr_hl),
    .rr_lh   (rr_lh),
    .rr_ll   (rr_ll)
  );

  // stages 5-6: rebuild the squares, compare distance against radius
  scpt_decide #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_i    (vld4),
    .flags_i  (flags4),
    .sq_hh    (sq_hh),
    .sq_hl    (sq_hl),
    .sq_ll    (sq_ll),
    .rr_hh    (rr_hh),
    .rr_hl    (rr_hl),
    .rr_lh    (rr_lh),
    .rr_ll    (rr_ll),
    .vld_o    (out_valid),
    .inside_o (out_inside_res),
    .deg_o    (out_degenerate)
  );

endmodule

// ----- test/segment_cylinder_point_test_top_test.sv -----
`timescale 1ns / 100ps

// Point-in-finite-cylinder pipeline: directed requests first, then ~600 random ones.
// Every accepted request is scored by a local 128-bit exact predictor or by its hand-written verdict.
// Results are compared in order against the queue of outstanding verdicts.
module segment_cylinder_point_test_top_test;
  import scpt_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 16;      // pipe depth is six, plus margin
  localparam int RANDOM_COUNT = 600;
  localparam int QUIET_FROM   = 520;     // no idling on either side from here on
  localparam int HOLD_CYCLES  = 40;      // long receiver hold-off, fills the pipe

  typedef logic signed [COORD_BITS_DEF-1:0] coord_t;
  typedef logic        [COORD_BITS_DEF-2:0] radius_t;
  // widest term is |c|^2, about 2^100, so 128 bits keeps everything exact
  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic contained;
    logic degen;
  } verdict_t;

  typedef struct {
    coord_t   sx, sy, sz;
    coord_t   ex, ey, ez;
    coord_t   qx, qy, qz;
    radius_t  r;
    bit       typed;          // verdict below was written by hand
    verdict_t typed_verdict;
  } probe_t;

  // degenerate axis when |e-s|^2 * 10^6 < 2^(2*FRAC)
  localparam wide_t DEG_SCALE_W = 1000000;
  localparam wide_t DEG_LIMIT_W = wide_t'(1) << (2 * FRAC_BITS_DEF);

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  logic    out_valid;
  logic    out_stall = 1'b0;
  logic    out_inside_res;
  logic    out_degenerate;

  // request currently on offer; the ports follow it
  probe_t  on_offer = '{default: 0};

  verdict_t pending_verdicts[$];
  int       mismatches = 0;
  int       cycles = 0;
  bit       quiet = 1'b0;         // set for the tail of the run
  bit       long_hold_req = 1'b0; // sender asks receiver for one long hold-off
  int       hold_count;

  always #1 clk = ~clk;

  segment_cylinder_point_test_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_start_x    (on_offer.sx),
    .in_start_y    (on_offer.sy),
    .in_start_z    (on_offer.sz),
    .in_end_x      (on_offer.ex),
    .in_end_y      (on_offer.ey),
    .in_end_z      (on_offer.ez),
    .in_query_x    (on_offer.qx),
    .in_query_y    (on_offer.qy),
    .in_query_z    (on_offer.qz),
    .in_cyl_radius (on_offer.r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_inside_res(out_inside_res),
    .out_degenerate(out_degenerate)
  );

  // ---------------------------------------------------------------- predictor

  function automatic wide_t widen(input coord_t c);
    return c;  // signed, so sign-extended
  endfunction

  function automatic wide_t dot3(input wide_t x[3], input wide_t y[3]);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  function automatic verdict_t predict_containment(input probe_t p);
    wide_t    s[3], e[3], q[3], d[3], nd[3], a[3], b[3], c[3];
    wide_t    dd, lhs, rhs, rw;
    verdict_t v;
    s[0] = widen(p.sx); s[1] = widen(p.sy); s[2] = widen(p.sz);
    e[0] = widen(p.ex); e[1] = widen(p.ey); e[2] = widen(p.ez);
    q[0] = widen(p.qx); q[1] = widen(p.qy); q[2] = widen(p.qz);
    for (int i = 0; i < 3; i++) begin
      d[i]  = e[i] - s[i];
      nd[i] = s[i] - e[i];
      a[i]  = q[i] - s[i];
      b[i]  = q[i] - e[i];
    end
    dd = dot3(d, d);
    v.degen = (dd * DEG_SCALE_W) < DEG_LIMIT_W;
    // short axis is treated as a collision
    if (v.degen) begin
      v.contained = 1'b1;
      return v;
    end
    v.contained = 1'b0;
    // on a cap plane the dot product is zero, which still counts as between
    if (dot3(a, d) < 0 || dot3(b, nd) < 0) return v;
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    lhs = dot3(c, c);
    rw  = p.r;  // unsigned, zero-extended
    rhs = rw * rw * dd;
    v.contained = lhs < rhs;  // strict: exactly on the radius is outside
    return v;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic probe_t probe_row(
    input coord_t sx, sy, sz, ex, ey, ez, qx, qy, qz,
    input radius_t r, input bit typed = 1'b0, input bit contained = 1'b0,
    input bit degen = 1'b0
  );
    probe_t p;
    p.sx = sx; p.sy = sy; p.sz = sz;
    p.ex = ex; p.ey = ey; p.ez = ez;
    p.qx = qx; p.qy = qy; p.qz = qz;
    p.r  = r;
    p.typed = typed;
    p.typed_verdict.contained = contained;
    p.typed_verdict.degen     = degen;
    return p;
  endfunction

  function automatic int spread(input int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  // Mostly well-formed geometry at a random scale, so both caps and the
  // radius bound are exercised; a fifth is raw noise over every bit.
  function automatic probe_t random_probe();
    probe_t p;
    int     kind, mag, k;
    int     s[3], e[3], q[3];
    int     rad;
    p = '{default: 0};
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      p.sx = coord_t'($urandom()); p.sy = coord_t'($urandom()); p.sz = coord_t'($urandom());
      p.ex = coord_t'($urandom()); p.ey = coord_t'($urandom()); p.ez = coord_t'($urandom());
      p.qx = coord_t'($urandom()); p.qy = coord_t'($urandom()); p.qz = coord_t'($urandom());
      p.r  = radius_t'($urandom());
      return p;
    end
    if (kind == 9) begin
      // full-range axis, query near its middle
      for (int i = 0; i < 3; i++) begin
        s[i] = spread(8388607);
        e[i] = spread(8388607);
        q[i] = (s[i] + e[i]) / 2 + spread(1 << 20);
      end
      rad = int'($urandom_range(0, 8388607));
    end else begin
      // kind 2 sits around the degenerate length threshold
      mag = (kind == 2) ? 5 : (1 << $urandom_range(2, 20));
      k   = int'($urandom_range(0, 18)) - 1;  // -1..17 sixteenths along the axis
      for (int i = 0; i < 3; i++) begin
        s[i] = spread(1 << 22);
        e[i] = s[i] + spread(mag);
        q[i] = s[i] + ((e[i] - s[i]) * k) / 16 + spread(mag);
      end
      rad = int'($urandom_range(0, 2 * mag));
    end
    p.sx = coord_t'(s[0]); p.sy = coord_t'(s[1]); p.sz = coord_t'(s[2]);
    p.ex = coord_t'(e[0]); p.ey = coord_t'(e[1]); p.ez = coord_t'(e[2]);
    p.qx = coord_t'(q[0]); p.qy = coord_t'(q[1]); p.qz = coord_t'(q[2]);
    p.r  = radius_t'(rad);
    return p;
  endfunction

  // present one request and hold it until it is taken
  task automatic offer(input probe_t p);
    @(negedge clk);
    on_offer = p;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_sender(input int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch, cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- scoreboard
  // Requests and results are both seen at the rising edge, before any flop
  // in the block updates.

  always @(posedge clk) begin : score
    verdict_t oldest;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (on_offer.typed) pending_verdicts = {pending_verdicts, on_offer.typed_verdict};
        else pending_verdicts = {pending_verdicts, predict_containment(on_offer)};
      end
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          oldest = pending_verdicts[0];
          pending_verdicts.delete(0);
          if (out_inside_res !== oldest.contained)
            report_mismatch($sformatf("inside_res %b, expected %b",
                                      out_inside_res, oldest.contained));
          if (out_degenerate !== oldest.degen)
            report_mismatch($sformatf("degenerate %b, expected %b",
                                      out_degenerate, oldest.degen));
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  // Random stall bursts; on request one long hold-off, counted here, so the
  // pipe fills and in_stall has to rise.

  initial begin
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall = 1'b1;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES) begin
          @(negedge clk);
          hold_count++;
        end
        out_stall = 1'b0;
        long_hold_req = 1'b0;
      end else if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- sender

  initial begin : sender
    probe_t directed_rows[$];
    int     gap_chance;

    // axis along x, one unit long (4096), used by several of the rows below
    // all zero: degenerate, even with zero radius
    directed_rows = {directed_rows, probe_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1)};
    // coincident ends at the top of the range, far query
    directed_rows = {directed_rows,
                     probe_row(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                               -8388608, -8388608, -8388608, 23'h7fffff, 1, 1, 1)};
    // coincident ends at the bottom of the range
    directed_rows = {directed_rows,
                     probe_row(-8388608, -8388608, -8388608, -8388608, -8388608,
                               -8388608, 8388607, 8388607, 8388607, 0, 1, 1, 1)};
    // point on the axis, halfway
    directed_rows = {directed_rows,
                     probe_row(0, 0, 0, 4096, 0, 0, 2048, 0, 0, 1024, 1, 1, 0)};
    // zero radius never contains the point unless the axis is degenerate
    directed_rows = {directed_rows,
                     probe_row(0, 0, 0, 4096, 0, 0, 2048, 0, 0, 0, 1, 0, 0)};
    // on the start cap plane, within the radius
    directed_rows = {directed_rows,
                     probe_row(0, 0, 0, 4096, 0, 0, 0, 512, 0, 1024, 1, 1, 0)};
    // on the end cap plane, within the radius
    directed_rows = {directed_rows,
                     probe_row(0, 0, 0, 4096, 0, 0, 4096, 0, 512, 1024, 1, 1, 0)};
    // exactly at the radius: outside
    directed_rows = {directed_rows,
                     probe_row(0, 0, 0, 4096, 0, 0, 2048, 1024, 0, 1024, 1, 0, 0)};
    // just past the end cap
    directed_rows = {directed_rows,
                     probe_row(0, 0, 0, 4096, 0, 0, 4097, 0, 0, 1024, 1, 0, 0)};
    // just behind the start cap
    directed_rows = {directed_rows,
                     probe_row(0, 0, 0, 4096, 0, 0, -1, 0, 0, 1024, 1, 0, 0)};
    // squared length 16: still below the minimum length
    directed_rows = {directed_rows,
                     probe_row(0, 0, 0, 4, 0, 0, 5000, 5000, 5000, 0, 1, 1, 1)};
    // squared length 25: just long enough
    directed_rows = {directed_rows,
                     probe_row(0, 0, 0, 5, 0, 0, 2, 0, 0, 1, 1, 1, 0)};
    // squared length 17, off-axis query
    directed_rows = {directed_rows,
                     probe_row(100, -100, 7, 104, -99, 7, 102, -99, 8, 2)};
    // axis pointing into the negative octant
    directed_rows = {directed_rows,
                     probe_row(0, 0, 0, -4096, -4096, -4096, -2048, -2048, -2047, 1)};
    // full-range diagonal, query at the end, widest radius
    directed_rows = {directed_rows,
                     probe_row(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                               8388607, 8388607, 8388607, 23'h7fffff)};
    // full-range diagonal reversed, query at origin, zero radius
    directed_rows = {directed_rows,
                     probe_row(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                               0, 0, 0, 0)};
    // long axis, far off-axis query at the extremes
    directed_rows = {directed_rows,
                     probe_row(-8388608, 0, 0, 8388607, 0, 0,
                               0, 8388607, -8388608, 23'h7fffff)};
    // alternating bit patterns, both phases
    directed_rows = {directed_rows,
                     probe_row(24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555,
                               24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555,
                               24'haaaaaa, 23'h2aaaaa)};
    directed_rows = {directed_rows,
                     probe_row(24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa,
                               24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa,
                               24'h555555, 23'h555555)};

    // reset: released on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      offer(directed_rows[i]);
      if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 12));
    end

    gap_chance = 0;
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      // idling density changes in blocks, so some stretches run back to back
      if (n % 50 == 0) gap_chance = 25 * $urandom_range(0, 2);
      if (n == 150 || n == 430) long_hold_req = 1'b1;
      if (n == 300) begin
        // sender pause: let every outstanding result come back first
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
      end
      if (n == QUIET_FROM) quiet = 1'b1;
      offer(random_probe());
      if (!quiet && $urandom_range(0, 99) < gap_chance) idle_sender($urandom_range(1, 12));
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
